[design/lrs_pkg.sv]
// Shared types and constants of the linear resampler.
package lrs_pkg;

  localparam int SampleW  = 16;
  localparam int LenW     = 13;
  localparam int IndexW   = 12;
  localparam int StepW    = 27;
  localparam int PhaseW   = 28;
  localparam int FracW    = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 27;
  localparam int ResultsCap = 64;
  localparam int CountW   = $clog2(ResultsCap) + 1;

  localparam logic [CfgIdxW-1:0] CFG_IN_LENGTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OUT_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP       = 2'd2;

  localparam logic [PhaseW-1:0] PhaseMax = {PhaseW{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_t;

  // Operands handed to the blend unit for one result.
  typedef struct packed {
    logic [SampleW-1:0] prev;
    logic [SampleW-1:0] cur;
    logic [FracW-1:0]   frac;
    logic               pass;
  } blend_req_t;

endpackage

[design/lrs_if.sv]
// Stream interfaces for the source samples and the resampled results.
interface lrs_in_if
  import lrs_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
  modport mon    (input valid, input sample, input ready);
endinterface

interface lrs_out_if
  import lrs_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] value;
  logic [IndexW-1:0]  out_index;
  logic               run_last;
  logic               table_done;

  modport source (output valid, output value, output out_index, output run_last,
                  output table_done, input ready);
  modport sink   (input valid, input value, input out_index, input run_last,
                  input table_done, output ready);
  modport mon    (input valid, input value, input out_index, input run_last,
                  input table_done, input ready);
endinterface

[design/linear_resampler.sv]
// Top level of the streaming linear-interpolation resampler.
//
// Source samples arrive on in_s, one table of in_length samples after
// another; the interpolated table of out_length values leaves on out_s,
// each result carrying its index, a run_last flag on the final result of
// the request and table_done on the final value of the table.
// Lengths and the Q11.16 step are written through the cfg_ port; the user must
// write them only while the block is idle, which the block itself does not
// enforce, and the step should equal in_length/out_length.
// The next request is taken in the cycle after the last result of the current
// one is loaded into the output register. A single shared multiplier under a
// small sequencer produces the blended values, one result at a time. A
// table's final sample flushes the remaining results, at most 64 per request.
// Reset restores the default lengths and step and clears the counters, so
// a new table starts. When the receiver stalls, the result stays in the
// output register and the sequencer holds the next one until the register is free.
module linear_resampler
  import lrs_pkg::*;
#(
  parameter int MAX_LENGTH = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  lrs_in_if.sink              in_s,
  lrs_out_if.source           out_s
);

  localparam logic [LenW+3:0] MaxLen = (LenW+4)'(MAX_LENGTH);

  state_t state_r, state_nxt;

  logic [LenW-1:0]    in_length_r, out_length_r;
  logic [StepW-1:0]   step_r;
  logic [LenW-1:0]    ilen, olen, last_in;
  logic [SampleW-1:0] cur_r, prev_r;
  logic [IndexW-1:0]  ic_r;
  logic [LenW-1:0]    oc_r;
  logic [PhaseW-1:0]  phase_r;
  logic [PhaseW:0]    phase_sum;
  logic [CountW-1:0]  n_r;
  logic               final_r;
  logic [IndexW-1:0]  idx_r;

  logic               more, out_free, accept, issue, finish, emit;
  blend_req_t         breq;
  logic [SampleW-1:0] blend_value;

  logic               out_valid_r, out_run_last_r, out_table_done_r;
  logic [SampleW-1:0] out_value_r;
  logic [IndexW-1:0]  out_index_r;

  assign ilen = ({4'b0, in_length_r} > MaxLen) ? MaxLen[LenW-1:0] : in_length_r;
  assign olen = ({4'b0, out_length_r} > MaxLen) ? MaxLen[LenW-1:0] : out_length_r;
  assign last_in = (ilen > LenW'(1)) ? ilen - LenW'(1) : '0;

  // Another result is due while below the cap and out_length, and either its
  // position lies behind the current sample or this is the table's final sample.
  assign more = !n_r[CountW-1] && (oc_r < olen) &&
                ((phase_r[PhaseW-1:FracW] < ic_r) || final_r);
  assign out_free = !out_valid_r || out_s.ready;
  assign phase_sum = {1'b0, phase_r} + (PhaseW+1)'(step_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_s.valid) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = more ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (out_free) state_nxt = more ? ST_EVAL : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    accept = 1'b0;
    issue  = 1'b0;
    finish = 1'b0;
    emit   = 1'b0;
    case (state_r)
      ST_IDLE: accept = in_s.valid;
      ST_EVAL: begin
        issue  = more;
        finish = !more;
      end
      ST_EMIT: begin
        emit   = out_free;
        finish = out_free && !more;
      end
      default: ;
    endcase
  end

  assign in_s.ready = (state_r == ST_IDLE);

  assign breq.prev = prev_r;
  assign breq.cur  = cur_r;
  assign breq.frac = phase_r[FracW-1:0];
  assign breq.pass = !(phase_r[PhaseW-1:FracW] < ic_r);

  lrs_blend u_blend (
    .clk   (clk),
    .issue (issue),
    .req   (breq),
    .value (blend_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_length_r  <= LenW'(256);
      out_length_r <= LenW'(256);
      step_r       <= StepW'(65536);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IN_LENGTH:  in_length_r  <= cfg_wdata[LenW-1:0];
        CFG_OUT_LENGTH: out_length_r <= cfg_wdata[LenW-1:0];
        CFG_STEP:       step_r       <= cfg_wdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      prev_r  <= '0;
      ic_r    <= '0;
      oc_r    <= '0;
      phase_r <= '0;
      n_r     <= '0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cur_r   <= in_s.sample;
        n_r     <= '0;
        final_r <= ({1'b0, ic_r} >= last_in);
      end
      if (issue) begin
        idx_r   <= oc_r[IndexW-1:0];
        oc_r    <= oc_r + LenW'(1);
        n_r     <= n_r + CountW'(1);
        phase_r <= phase_sum[PhaseW] ? PhaseMax : phase_sum[PhaseW-1:0];
      end
      if (finish) begin
        prev_r <= cur_r;
        if (final_r) begin
          ic_r    <= '0;
          oc_r    <= '0;
          phase_r <= '0;
        end else begin
          ic_r <= ic_r + IndexW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r      <= blend_value;
      out_index_r      <= idx_r;
      out_run_last_r   <= !more;
      out_table_done_r <= (oc_r == olen);
    end
  end

  assign out_s.valid      = out_valid_r;
  assign out_s.value      = out_value_r;
  assign out_s.out_index  = out_index_r;
  assign out_s.run_last   = out_run_last_r;
  assign out_s.table_done = out_table_done_r;

endmodule

[design/lrs_blend.sv]
// Shared blend unit: one signed multiply, registered, then the rounding add.
module lrs_blend
  import lrs_pkg::*;
(
  input  logic               clk,
  input  logic               issue,
  input  blend_req_t         req,
  output logic [SampleW-1:0] value
);

  logic signed [SampleW:0]     diff;
  logic signed [SampleW:0]     frac_s;
  logic signed [2*SampleW+1:0] prod_r;
  logic signed [2*SampleW+1:0] sum;
  logic [SampleW-1:0]          base_r;
  logic [SampleW-1:0]          cur_r;
  logic                        pass_r;

  // prev*(1-f) + cur*f is rewritten as prev + (cur-prev)*f, one product.
  assign diff   = $signed({1'b0, req.cur}) - $signed({1'b0, req.prev});
  assign frac_s = $signed({1'b0, req.frac});

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= diff * frac_s;
      base_r <= req.prev;
      cur_r  <= req.cur;
      pass_r <= req.pass;
    end
  end

  assign sum   = $signed({2'b00, base_r, 16'h8000}) + prod_r;
  assign value = pass_r ? cur_r : sum[2*SampleW-1:SampleW];

endmodule

[design/lrs_checker.sv]
// Port-level checks of the linear resampler, bound to the top level.
module lrs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_run_last,
  input logic out_table_done
);

  // A result waiting for the receiver is never withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one is in progress");

  // The final value of a table is always the last result of its request.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_done |-> out_run_last)
    else $error("table_done without run_last");

  // New results are only produced while a request is in progress.
  a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

bind linear_resampler lrs_checker u_lrs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_s.valid),
  .in_ready       (in_s.ready),
  .out_valid      (out_s.valid),
  .out_ready      (out_s.ready),
  .out_run_last   (out_s.run_last),
  .out_table_done (out_s.table_done)
);
